// ----- rtl/core/pnguf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared types, codes and helper functions of the PNG RGBA8 scanline unfilter.
// ----------------------------------------------------------------------------
package pnguf_pkg;

  // Width of the line width register.
  localparam int LINE_W = 13;

  // Filter codes as held for a row. An out-of-range filter byte becomes
  // FILT_BAD and is reconstructed like FILT_NONE.
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [2:0] FILT_BAD   = 3'd5;

  // Channel slots within one pixel, in stream order.
  localparam logic [1:0] SLOT_RED   = 2'd0;
  localparam logic [1:0] SLOT_GREEN = 2'd1;
  localparam logic [1:0] SLOT_BLUE  = 2'd2;
  localparam logic [1:0] SLOT_ALPHA = 2'd3;

  // One channel byte as classified by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] slot;
    logic [2:0] filt;
    logic       first_row;
    logic       row_end;
  } pnguf_item_t;

  // Pick the byte of a packed 0xAARRGGBB word that belongs to a channel slot.
  function automatic logic [7:0] chan_byte(input logic [31:0] word, input logic [1:0] slot);
    logic [7:0] res;
    case (slot)
      SLOT_RED:   res = word[23:16];
      SLOT_GREEN: res = word[15:8];
      SLOT_BLUE:  res = word[7:0];
      SLOT_ALPHA: res = word[31:24];
      default:    res = word[7:0];
    endcase
    return res;
  endfunction

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    logic [9:0] res;
    res = v[9] ? 10'(-v) : 10'(v);
    return res;
  endfunction

  // Paeth predictor. With p = a + b - c, the distances reduce to
  // |b - c|, |a - c| and |a + b - 2c|.
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] dbc;
    logic signed [9:0] dac;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        res;
    dbc = $signed({2'b00, b}) - $signed({2'b00, c});
    dac = $signed({2'b00, a}) - $signed({2'b00, c});
    pa  = abs10(dbc);
    pb  = abs10(dac);
    pc  = abs10(dbc + dac);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/pnguf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnguf_fifo
// Small register queue between the front end and the reconstruction back end.
// ----------------------------------------------------------------------------
module pnguf_fifo #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [ADDR_W-1:0] wptr;
  logic [ADDR_W-1:0] rptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Storage is written in place; no reset needed.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == ADDR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == ADDR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pnguf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnguf_front
// Byte classifier: tracks filter bytes, channel slots, columns and row ends,
// and hands each channel byte with its context to the back end.
// ----------------------------------------------------------------------------
module pnguf_front import pnguf_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int COL_W     = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LINE_W-1:0] cfg_wdata,
  input  logic              push,
  input  logic [7:0]        data_byte,
  input  logic              image_start,
  input  logic              q_full,
  output logic              q_push,
  output pnguf_item_t       q_item,
  output logic [COL_W-1:0]  q_col
);

  localparam int EW = (COL_W + 1 > LINE_W) ? COL_W + 1 : LINE_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

  logic [LINE_W-1:0] line_width;
  logic [2:0]        row_filter;
  logic              expect_filter;
  logic [1:0]        slot;
  logic [COL_W-1:0]  col;
  logic              first_row;

  logic              accept;
  logic              is_filter;
  logic [EW-1:0]     eff_width;
  logic [EW-1:0]     col_inc;
  logic              row_done;

  assign accept    = push && !q_full;
  assign is_filter = expect_filter || image_start;

  // Effective row width clamped to one through the store depth.
  always_comb begin
    if (line_width == '0) begin
      eff_width = EW'(1);
    end else if (EW'(line_width) > MAXW) begin
      eff_width = MAXW;
    end else begin
      eff_width = EW'(line_width);
    end
    col_inc  = EW'(col) + EW'(1);
    row_done = (col_inc >= eff_width);
  end

  // Channel bytes go to the queue with everything the back end needs.
  always_comb begin
    q_push           = accept && !is_filter;
    q_col            = col;
    q_item.data      = data_byte;
    q_item.slot      = slot;
    q_item.filt      = row_filter;
    q_item.first_row = first_row;
    q_item.row_end   = (slot == SLOT_ALPHA) && row_done;
  end

  // Row and column state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= LINE_W'(1);
      row_filter    <= FILT_NONE;
      expect_filter <= 1'b1;
      slot          <= SLOT_RED;
      col           <= '0;
      first_row     <= 1'b1;
    end else begin
      if (cfg_we) begin
        line_width <= cfg_wdata;
      end
      if (accept) begin
        if (is_filter) begin
          row_filter    <= (data_byte > 8'(FILT_PAETH)) ? FILT_BAD : data_byte[2:0];
          expect_filter <= 1'b0;
          slot          <= SLOT_RED;
          col           <= '0;
          first_row     <= first_row || image_start;
        end else begin
          slot <= slot + 1'b1;
          if (slot == SLOT_ALPHA) begin
            if (row_done) begin
              col           <= '0;
              expect_filter <= 1'b1;
              first_row     <= 1'b0;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/pnguf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnguf_back
// Reconstruction back end: reads the row above, undoes the filter for each
// channel byte, stores finished pixels and presents them as output words.
// ----------------------------------------------------------------------------
module pnguf_back import pnguf_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int COL_W     = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pnguf_item_t      q_item,
  input  logic [COL_W-1:0] q_col,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [31:0]      pixel_word,
  output logic             row_end,
  output logic             bad_filter
);

  // Previous-row store, one packed pixel per column.
  logic [31:0]      store [MAX_WIDTH];
  logic [31:0]      store_rd;
  logic             fwd_hit;
  logic [31:0]      fwd_pix;

  // Execute stage.
  logic             b_valid;
  pnguf_item_t      b_item;
  logic [COL_W-1:0] b_col;

  // Row context kept between pixels.
  logic [31:0]      left_pix;
  logic [31:0]      ul_pix;
  logic [7:0]       red_byte;
  logic [7:0]       green_byte;
  logic [7:0]       blue_byte;

  // Output word register.
  logic             out_valid;
  logic             out_ready;

  logic             b_last;
  logic             b_go;
  logic [31:0]      upper;
  logic [7:0]       nb_a;
  logic [7:0]       nb_b;
  logic [7:0]       nb_c;
  logic [8:0]       ab_sum;
  logic [7:0]       pred;
  logic [7:0]       chan;
  logic [31:0]      pix;

  assign empty     = !out_valid;
  assign out_ready = !out_valid || pop;
  assign b_last    = (b_item.slot == SLOT_ALPHA);
  assign b_go      = b_valid && (!b_last || out_ready);
  assign q_pop     = !q_empty && (!b_valid || b_go);

  // Neighbors: nothing above the first row, nothing left of column zero.
  always_comb begin
    upper  = b_item.first_row ? 32'd0 : (fwd_hit ? fwd_pix : store_rd);
    nb_a   = (b_col == '0) ? 8'd0 : chan_byte(left_pix, b_item.slot);
    nb_b   = chan_byte(upper, b_item.slot);
    nb_c   = (b_col == '0) ? 8'd0 : chan_byte(ul_pix, b_item.slot);
    ab_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (b_item.filt)
      FILT_SUB:   pred = nb_a;
      FILT_UP:    pred = nb_b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
      default:    pred = 8'd0;
    endcase
    chan = b_item.data + pred;
    pix  = {chan, red_byte, green_byte, blue_byte};
  end

  // Store read for the item entering the execute stage. A pixel being
  // written in the same cycle to the same column is forwarded instead.
  always_ff @(posedge clk) begin
    if (b_go && b_last) begin
      store[b_col] <= pix;
    end
    if (q_pop) begin
      store_rd <= store[q_col];
      fwd_hit  <= b_go && b_last && (b_col == q_col);
      fwd_pix  <= pix;
    end
  end

  // Execute stage load.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (q_pop) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item <= q_item;
      b_col  <= q_col;
    end
  end

  // Partial pixel and neighbor context.
  always_ff @(posedge clk) begin
    if (b_go) begin
      case (b_item.slot)
        SLOT_RED:   red_byte   <= chan;
        SLOT_GREEN: green_byte <= chan;
        SLOT_BLUE:  blue_byte  <= chan;
        SLOT_ALPHA: begin
          left_pix <= pix;
          ul_pix   <= upper;
        end
        default: begin
          red_byte <= chan;
        end
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_last) begin
      pixel_word <= pix;
      row_end    <= b_item.row_end;
      bad_filter <= (b_item.filt == FILT_BAD);
    end
  end

  // Color bytes never wait on the output side.
  a_color_no_stall: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_last |-> b_go)
    else $error("color byte stalled in execute stage");

  // A popped item is in the execute stage on the next cycle.
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> b_valid)
    else $error("popped item lost before execute stage");

  // A finished pixel is presented on the next cycle.
  a_pixel_out: assert property (@(posedge clk) disable iff (rst)
    b_go && b_last |=> out_valid)
    else $error("finished pixel not presented");

  // A row ends only on an alpha byte.
  a_row_end_alpha: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_item.row_end |-> b_last)
    else $error("row end marked on a color byte");

endmodule

// ----- rtl/core/png_rgba8_scanline_unfilter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_rgba8_scanline_unfilter_unit
// PNG scanline unfilter for 8-bit RGBA data, one inflated byte per cycle while full is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input bytes are pushed with push while full is low. Each row starts with
//   its filter byte, followed by R, G, B, A bytes per pixel. image_start on a
//   byte restarts row state and takes that byte as the first filter byte.
//   cfg_we/cfg_wdata write the row width in pixels; the user must do so only while the block
//   is idle, which the block does not enforce. Each finished pixel appears as one word on
//   pixel_word (0xAARRGGBB) with row_end and bad_filter while empty is low; pop takes it.
// Timing:
//   One byte is accepted per cycle while full is low, so a pixel word leaves per four
//   bytes, plus one filter byte per row. An accepted byte is written into the queue,
//   moves from there into the execute stage, and an alpha byte then loads its pixel
//   word into the output register, where it becomes visible. The previous-row store
//   has one read and one write port; its read is registered and loaded together with
//   the execute stage when an item leaves the queue.
// Reset and stalls:
//   rst clears all control state and sets the row width to one; the store is
//   not cleared. When pop stays low, one pixel word waits in the output
//   register, the queue fills, and full rises until pop resumes.
// ----------------------------------------------------------------------------
module png_rgba8_scanline_unfilter_unit import pnguf_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LINE_W-1:0] cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              image_start,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       pixel_word,
  output logic              row_end,
  output logic              bad_filter
);

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ITEM_W  = $bits(pnguf_item_t);
  localparam int QWORD_W = ITEM_W + COL_W;

  logic               q_push;
  pnguf_item_t        q_in_item;
  logic [COL_W-1:0]   q_in_col;
  logic               q_pop;
  logic [QWORD_W-1:0] q_out;
  logic               q_full;
  logic               q_empty;
  pnguf_item_t        q_out_item;
  logic [COL_W-1:0]   q_out_col;

  assign full       = q_full;
  assign q_out_item = q_out[ITEM_W-1:0];
  assign q_out_col  = q_out[QWORD_W-1:ITEM_W];

  // Front end: byte classification.
  pnguf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .data_byte   (data_byte),
    .image_start (image_start),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in_item),
    .q_col       (q_in_col)
  );

  // Queue between front and back end.
  pnguf_fifo #(
    .WIDTH (QWORD_W),
    .DEPTH (4)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data ({q_in_col, q_in_item}),
    .rd_en   (q_pop),
    .rd_data (q_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end: reconstruction and output.
  pnguf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (q_out_item),
    .q_col      (q_out_col),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .pixel_word (pixel_word),
    .row_end    (row_end),
    .bad_filter (bad_filter)
  );

endmodule
